>>> hw/rtl/lss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lss_pkg: shared types and constants for the line sensor steering block
// Register indexes, reset values, filter weights, sequencer states and the
// structs passed between the decoder, the multiply-accumulate unit and top.
// ----------------------------------------------------------------------------
package lss_pkg;

  localparam int SENSOR_COUNT = 12;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 10;
  localparam int STEER_W      = 19;
  localparam int POS_W        = 5;
  localparam int ACC_W        = 28;
  localparam int RAW_W        = 11;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_STRAIGHT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_CURVE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CURVE_THRESHOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_OFFSET    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT     = 3'd4;

  // register reset values
  localparam logic [7:0] RST_GAIN_STRAIGHT   = 8'd14;
  localparam logic [7:0] RST_GAIN_CURVE      = 8'd24;
  localparam logic [3:0] RST_CURVE_THRESHOLD = 4'd5;
  localparam logic [7:0] RST_DRIVE_OFFSET    = 8'd8;
  localparam logic [9:0] RST_DRIVE_LIMIT     = 10'd500;

  // Q8 filter weights, each pair sums to 256
  localparam logic [7:0] COEF_FILT_OLD = 8'd154;
  localparam logic [7:0] COEF_FILT_NEW = 8'd102;
  localparam logic [7:0] COEF_MIX_NEW  = 8'd205;
  localparam logic [7:0] COEF_MIX_OLD  = 8'd51;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_GAIN,
    ST_CLAMP,
    ST_FILT_A,
    ST_FILT_B,
    ST_MIX_A,
    ST_MIX_B,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                    zero;
    logic                    hit;
    logic signed [POS_W-1:0] pos;
  } decode_t;

  typedef struct packed {
    logic                      en;
    logic                      clear;
    logic signed [STEER_W-1:0] a;
    logic        [7:0]         b;
  } mac_op_t;

endpackage
`default_nettype wire

>>> hw/rtl/lss_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lss_if: valid/ready channels of the line sensor steering block
// Sample channel carries the sensor bits; result channel carries the
// steering command, the decoded position and the line lost flag.
// ----------------------------------------------------------------------------
interface lss_sample_if;
  logic                            valid;
  logic                            ready;
  logic [lss_pkg::SENSOR_COUNT-1:0] sensor_bits;

  modport source (output valid, output sensor_bits, input ready);
  modport sink (input valid, input sensor_bits, output ready);
endinterface

interface lss_result_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [lss_pkg::STEER_W-1:0]   steer_q8;
  logic signed [lss_pkg::POS_W-1:0]     line_position;
  logic                                 line_lost;

  modport source (output valid, output steer_q8, output line_position,
                  output line_lost, input ready);
  modport sink (input valid, input steer_q8, input line_position,
                input line_lost, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/lss_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lss_decode: line position decoder
// Matches one, two or three adjacent lit sensors and gives twice the
// centroid minus eleven; flags the all-dark pattern.
// ----------------------------------------------------------------------------
module lss_decode (
  input  wire logic [lss_pkg::SENSOR_COUNT-1:0] bits,
  output lss_pkg::decode_t                      dec
);

  localparam int N = lss_pkg::SENSOR_COUNT;

  always_comb begin
    dec.zero = (bits == '0);
    dec.hit  = 1'b0;
    dec.pos  = '0;
    for (int i = 0; i < N; i++) begin
      if (bits == N'(1 << i)) begin
        dec.hit = 1'b1;
        dec.pos = lss_pkg::POS_W'(2 * i - 11);
      end
      if (i + 1 < N && bits == N'(3 << i)) begin
        dec.hit = 1'b1;
        dec.pos = lss_pkg::POS_W'(2 * i - 10);
      end
      if (i + 2 < N && bits == N'(7 << i)) begin
        dec.hit = 1'b1;
        dec.pos = lss_pkg::POS_W'(2 * i - 9);
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/lss_mac.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lss_mac: shared multiply-accumulate unit
// Signed 19-bit operand times unsigned 8-bit weight, loaded into or added
// to a 28-bit accumulator under control of the sequencer.
// ----------------------------------------------------------------------------
module lss_mac (
  input  wire logic                                clk,
  input  wire lss_pkg::mac_op_t                    op,
  output logic signed [lss_pkg::ACC_W-1:0]         acc
);

  logic signed [lss_pkg::ACC_W-1:0] prod;
  logic signed [lss_pkg::ACC_W-1:0] base;

  assign prod = op.a * $signed({1'b0, op.b});
  assign base = op.clear ? '0 : acc;

  always_ff @(posedge clk) begin
    if (op.en) begin
      acc <= base + prod;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/line_sensor_steering.sv
`default_nettype none
// ----------------------------------------------------------------------------
// line_sensor_steering: proportional steering from a 12-bit line sensor bar
// Decodes the line position, applies gain, offset and clamp, then runs a
// two-step Q8 smoothing filter on one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                  | handshake
//  ---------+-----+------------------------------------------+-------------
//  sample   | in  | sensor_bits[11:0]                        | valid/ready
//  result   | out | steer_q8[18:0], line_position, line_lost | valid/ready
//  cfg      | in  | cfg_index[2:0], cfg_data[9:0]            | cfg_we only
//
//  An item passes from accept to result valid through decode, gain multiply,
//  offset and clamp, two filter MAC steps, two blend MAC steps, output load;
//  an all-dark item skips gain, clamp and filter.
//  Sample ready is high only while the sequencer is idle, in the cycle after the
//  result loads at the earliest, and a new item is taken while a result waits.
//  A stalled result holds the sequencer in its last step; reset is synchronous.
// ----------------------------------------------------------------------------
module line_sensor_steering (
  input  wire logic                              clk,
  input  wire logic                              rst,
  lss_sample_if.sink                             sample,
  lss_result_if.source                           result,
  input  wire logic                              cfg_we,
  input  wire logic [lss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [lss_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int SW = lss_pkg::STEER_W;
  localparam int PW = lss_pkg::POS_W;
  localparam int AW = lss_pkg::ACC_W;
  localparam int RW = lss_pkg::RAW_W;

  lss_pkg::state_t  state, state_next;
  lss_pkg::decode_t dec;
  lss_pkg::mac_op_t mac_op;

  logic [7:0] gain_straight;
  logic [7:0] gain_curve;
  logic [3:0] curve_threshold;
  logic [7:0] drive_offset;
  logic [9:0] drive_limit;

  logic [lss_pkg::SENSOR_COUNT-1:0] bits;
  logic signed [PW-1:0] held_position;
  logic signed [SW-1:0] smoothed_drive;
  logic signed [SW-1:0] snew;
  logic signed [RW-1:0] raw, raw_next;
  logic                 lost;

  logic                 out_valid;
  logic signed [SW-1:0] out_steer;
  logic signed [PW-1:0] out_pos;
  logic                 out_lost;

  logic signed [AW-1:0] acc;
  logic signed [SW-1:0] acc_q8;
  logic signed [PW-1:0] neg_pos;
  logic        [PW-1:0] abs_pos;
  logic        [7:0]    gain;
  logic signed [13:0]   drive_in, drive_adj, lim_pos, lim_neg;
  logic                 out_load;

  lss_decode u_decode (
    .bits (bits),
    .dec  (dec)
  );

  lss_mac u_mac (
    .clk (clk),
    .op  (mac_op),
    .acc (acc)
  );

  assign acc_q8   = acc[SW+7:8];
  assign neg_pos  = -held_position;
  assign abs_pos  = held_position[PW-1] ? neg_pos : held_position;
  assign gain     = (abs_pos >= {1'b0, curve_threshold}) ? gain_curve : gain_straight;
  assign out_load = (state == lss_pkg::ST_DONE) && (!out_valid || result.ready);

  // offset away from zero, then clamp to the symmetric limit
  always_comb begin
    drive_in = acc[13:0];
    lim_pos  = {4'b0, drive_limit};
    lim_neg  = -lim_pos;
    if (drive_in > 14'sd0) begin
      drive_adj = drive_in + $signed({6'b0, drive_offset});
    end else if (drive_in < 14'sd0) begin
      drive_adj = drive_in - $signed({6'b0, drive_offset});
    end else begin
      drive_adj = '0;
    end
    if (drive_adj > lim_pos) begin
      drive_adj = lim_pos;
    end else if (drive_adj < lim_neg) begin
      drive_adj = lim_neg;
    end
    raw_next = drive_adj[RW-1:0];
  end

  always_comb begin
    state_next   = state;
    mac_op.en    = 1'b0;
    mac_op.clear = 1'b0;
    mac_op.a     = '0;
    mac_op.b     = '0;
    case (state)
      lss_pkg::ST_IDLE: begin
        if (sample.valid) begin
          state_next = lss_pkg::ST_DECODE;
        end
      end
      lss_pkg::ST_DECODE: begin
        state_next = dec.zero ? lss_pkg::ST_MIX_A : lss_pkg::ST_GAIN;
      end
      lss_pkg::ST_GAIN: begin
        mac_op.en    = 1'b1;
        mac_op.clear = 1'b1;
        mac_op.a     = SW'(neg_pos);
        mac_op.b     = gain;
        state_next   = lss_pkg::ST_CLAMP;
      end
      lss_pkg::ST_CLAMP: begin
        state_next = lss_pkg::ST_FILT_A;
      end
      lss_pkg::ST_FILT_A: begin
        mac_op.en    = 1'b1;
        mac_op.clear = 1'b1;
        mac_op.a     = smoothed_drive;
        mac_op.b     = lss_pkg::COEF_FILT_OLD;
        state_next   = lss_pkg::ST_FILT_B;
      end
      lss_pkg::ST_FILT_B: begin
        mac_op.en  = 1'b1;
        mac_op.a   = {raw, 8'b0};
        mac_op.b   = lss_pkg::COEF_FILT_NEW;
        state_next = lss_pkg::ST_MIX_A;
      end
      lss_pkg::ST_MIX_A: begin
        mac_op.en    = 1'b1;
        mac_op.clear = 1'b1;
        mac_op.a     = lost ? smoothed_drive : acc_q8;
        mac_op.b     = lss_pkg::COEF_MIX_NEW;
        state_next   = lss_pkg::ST_MIX_B;
      end
      lss_pkg::ST_MIX_B: begin
        mac_op.en  = 1'b1;
        mac_op.a   = smoothed_drive;
        mac_op.b   = lss_pkg::COEF_MIX_OLD;
        state_next = lss_pkg::ST_DONE;
      end
      lss_pkg::ST_DONE: begin
        if (out_load) begin
          state_next = lss_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lss_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lss_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_straight   <= lss_pkg::RST_GAIN_STRAIGHT;
      gain_curve      <= lss_pkg::RST_GAIN_CURVE;
      curve_threshold <= lss_pkg::RST_CURVE_THRESHOLD;
      drive_offset    <= lss_pkg::RST_DRIVE_OFFSET;
      drive_limit     <= lss_pkg::RST_DRIVE_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        lss_pkg::REG_GAIN_STRAIGHT:   gain_straight   <= cfg_data[7:0];
        lss_pkg::REG_GAIN_CURVE:      gain_curve      <= cfg_data[7:0];
        lss_pkg::REG_CURVE_THRESHOLD: curve_threshold <= cfg_data[3:0];
        lss_pkg::REG_DRIVE_OFFSET:    drive_offset    <= cfg_data[7:0];
        lss_pkg::REG_DRIVE_LIMIT:     drive_limit     <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_position  <= '0;
      smoothed_drive <= '0;
      lost           <= 1'b0;
    end else begin
      case (state)
        lss_pkg::ST_IDLE: begin
          if (sample.valid) begin
            bits <= sample.sensor_bits;
          end
        end
        lss_pkg::ST_DECODE: begin
          lost <= dec.zero;
          if (dec.zero) begin
            held_position <= '0;
          end else if (dec.hit) begin
            held_position <= dec.pos;
          end
        end
        lss_pkg::ST_CLAMP: begin
          raw <= raw_next;
        end
        lss_pkg::ST_MIX_A: begin
          snew <= lost ? smoothed_drive : acc_q8;
        end
        lss_pkg::ST_MIX_B: begin
          // old value was used by this step; commit the new one
          smoothed_drive <= snew;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_steer <= acc_q8;
      out_pos   <= held_position;
      out_lost  <= lost;
    end
  end

  assign sample.ready         = (state == lss_pkg::ST_IDLE);
  assign result.valid         = out_valid;
  assign result.steer_q8      = out_steer;
  assign result.line_position = out_pos;
  assign result.line_lost     = out_lost;

`ifndef SYNTHESIS
  a_held_range : assert property (@(posedge clk) disable iff (rst)
    held_position >= -5'sd11 && held_position <= 5'sd11)
    else $error("held position out of range");

  a_accept_decode : assert property (@(posedge clk) disable iff (rst)
    sample.valid && sample.ready |=> state == lss_pkg::ST_DECODE)
    else $error("accepted item did not enter decode");

  a_raw_clamped : assert property (@(posedge clk) disable iff (rst)
    state == lss_pkg::ST_FILT_A |->
      $signed({raw[RW-1], raw}) <= $signed({2'b0, drive_limit}) &&
      $signed({raw[RW-1], raw}) >= -$signed({2'b0, drive_limit}))
    else $error("raw drive exceeds limit");

  a_lost_pos : assert property (@(posedge clk) disable iff (rst)
    out_load && lost |-> held_position == '0)
    else $error("lost line with nonzero position");
`endif

endmodule
`default_nettype wire

>>> bench/tb_line_sensor_steering.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_line_sensor_steering: self-checking bench for the line sensor steering
// Feeds sensor samples through the sample channel, mirrors the position
// decode, gain, offset, clamp and Q8 smoothing in a local model, and checks
// every steering result field by field. The registers are rewritten between
// drained phases, including the all-zero and all-ones settings. Both channels
// see random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_line_sensor_steering;

  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_SHOWN   = 30;

  typedef struct packed {
    logic signed [lss_pkg::STEER_W-1:0] steer;
    logic signed [lss_pkg::POS_W-1:0]   pos;
    logic                               lost;
  } steer_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                             src_valid = 1'b0;
  logic [lss_pkg::SENSOR_COUNT-1:0] src_bits  = '0;
  logic                             snk_ready = 1'b0;
  logic                             cfg_we    = 1'b0;
  logic [lss_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  logic [lss_pkg::CFG_DATA_W-1:0]   cfg_data  = '0;

  lss_sample_if sample_ch ();
  lss_result_if result_ch ();

  assign sample_ch.valid       = src_valid;
  assign sample_ch.sensor_bits = src_bits;
  assign result_ch.ready       = snk_ready;

  line_sensor_steering u_top (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // register mirror and filter state of the local model
  int                               gain_straight_m;
  int                               gain_curve_m;
  int                               threshold_m;
  int                               offset_m;
  int                               limit_m;
  logic signed [lss_pkg::POS_W-1:0] held_pos;
  longint                           smooth_q8;

  logic [lss_pkg::SENSOR_COUNT-1:0] sensor_queue[$];
  steer_result_t                    steer_expect[$];

  logic sample_taken = 1'b0;
  int   src_gap      = 0;
  int   snk_stall    = 0;
  int   src_mode     = 0;
  int   snk_mode     = 0;
  int   err_count    = 0;
  int   cycle_count  = 0;

  function automatic int idle_len(input int mode);
    int r;
    if (mode == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [lss_pkg::SENSOR_COUNT-1:0] random_sensor();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return lss_pkg::SENSOR_COUNT'(1 << $urandom_range(0, 11));
    if (r < 60) return lss_pkg::SENSOR_COUNT'(3 << $urandom_range(0, 10));
    if (r < 75) return lss_pkg::SENSOR_COUNT'(7 << $urandom_range(0, 9));
    if (r < 85) return '0;
    return lss_pkg::SENSOR_COUNT'($urandom_range(0, 4095));
  endfunction

  // decode, drive and filter one sample; advances the model state
  function automatic steer_result_t predict_steer(
    input logic [lss_pkg::SENSOR_COUNT-1:0] bits);
    steer_result_t r;
    longint        old_s;
    longint        new_s;
    longint        raw;
    int            gain;
    int            hp;
    int            abs_pos;
    int            b;
    logic          hit;
    old_s  = smooth_q8;
    new_s  = old_s;
    r.lost = 1'b0;
    b      = int'(bits);
    if (bits == '0) begin
      held_pos = '0;
      r.lost   = 1'b1;
    end else begin
      hit = 1'b0;
      for (int i = 0; i < lss_pkg::SENSOR_COUNT; i++) begin
        if (!hit) begin
          if (b == (1 << i)) begin
            held_pos = lss_pkg::POS_W'(2 * i - 11);
            hit      = 1'b1;
          end else if (i < lss_pkg::SENSOR_COUNT - 1 && b == (3 << i)) begin
            held_pos = lss_pkg::POS_W'(2 * i - 10);
            hit      = 1'b1;
          end else if (i < lss_pkg::SENSOR_COUNT - 2 && b == (7 << i)) begin
            held_pos = lss_pkg::POS_W'(2 * i - 9);
            hit      = 1'b1;
          end
        end
      end
      hp      = held_pos;
      abs_pos = (hp < 0) ? -hp : hp;
      gain    = (abs_pos >= threshold_m) ? gain_curve_m : gain_straight_m;
      raw     = longint'(gain) * longint'(-hp);
      if (raw > 0) raw = raw + offset_m;
      else if (raw < 0) raw = raw - offset_m;
      if (raw > limit_m) raw = limit_m;
      if (raw < -limit_m) raw = -limit_m;
      new_s     = (154 * old_s + 102 * (raw * 256)) >>> 8;
      smooth_q8 = new_s;
    end
    r.steer = lss_pkg::STEER_W'((205 * new_s + 51 * old_s) >>> 8);
    r.pos   = held_pos;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (err_count < MAX_SHOWN)
      $display("mismatch %s: got %0d, expected %0d", what, got, want);
    err_count++;
  endtask

  // sample source: hold the item until taken, then gap or load the next
  always @(negedge clk) begin
    if (rst) begin
      src_valid <= 1'b0;
      src_gap   <= 0;
    end else if (!src_valid || sample_taken) begin
      if (src_gap != 0) begin
        src_valid <= 1'b0;
        src_gap   <= src_gap - 1;
      end else if (sensor_queue.size() != 0) begin
        src_valid <= 1'b1;
        src_bits  <= sensor_queue.pop_front();
        src_gap   <= idle_len(src_mode);
      end else begin
        src_valid <= 1'b0;
      end
    end
  end

  // result sink: one ready cycle, then an optional stall
  always @(negedge clk) begin
    if (rst) begin
      snk_ready <= 1'b0;
      snk_stall <= 0;
    end else if (snk_stall != 0) begin
      snk_ready <= 1'b0;
      snk_stall <= snk_stall - 1;
    end else begin
      snk_ready <= 1'b1;
      snk_stall <= idle_len(snk_mode);
    end
  end

  always @(posedge clk) begin
    steer_result_t want;
    if (rst) begin
      sample_taken    <= 1'b0;
      gain_straight_m = lss_pkg::RST_GAIN_STRAIGHT;
      gain_curve_m    = lss_pkg::RST_GAIN_CURVE;
      threshold_m     = lss_pkg::RST_CURVE_THRESHOLD;
      offset_m        = lss_pkg::RST_DRIVE_OFFSET;
      limit_m         = lss_pkg::RST_DRIVE_LIMIT;
      held_pos        = '0;
      smooth_q8       = 0;
    end else begin
      sample_taken <= sample_ch.valid && sample_ch.ready;
      if (cfg_we) begin
        case (cfg_index)
          lss_pkg::REG_GAIN_STRAIGHT:   gain_straight_m = cfg_data[7:0];
          lss_pkg::REG_GAIN_CURVE:      gain_curve_m    = cfg_data[7:0];
          lss_pkg::REG_CURVE_THRESHOLD: threshold_m     = cfg_data[3:0];
          lss_pkg::REG_DRIVE_OFFSET:    offset_m        = cfg_data[7:0];
          lss_pkg::REG_DRIVE_LIMIT:     limit_m         = cfg_data[9:0];
          default: ;
        endcase
      end
      if (sample_ch.valid && sample_ch.ready)
        steer_expect.push_back(predict_steer(sample_ch.sensor_bits));
      if (result_ch.valid && result_ch.ready) begin
        if (steer_expect.size() == 0) begin
          report_mismatch("unexpected result, steer_q8", result_ch.steer_q8, 0);
        end else begin
          want = steer_expect.pop_front();
          if (result_ch.steer_q8 !== want.steer)
            report_mismatch("steer_q8", result_ch.steer_q8, want.steer);
          if (result_ch.line_position !== want.pos)
            report_mismatch("line_position", result_ch.line_position, want.pos);
          if (result_ch.line_lost !== want.lost)
            report_mismatch("line_lost", result_ch.line_lost, want.lost);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("line_sensor_steering test failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [lss_pkg::CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= lss_pkg::CFG_DATA_W'(value);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_config(input int gs, input int gc, input int thr, input int off,
                            input int lim);
    write_reg(lss_pkg::REG_GAIN_STRAIGHT, gs);
    write_reg(lss_pkg::REG_GAIN_CURVE, gc);
    write_reg(lss_pkg::REG_CURVE_THRESHOLD, thr);
    write_reg(lss_pkg::REG_DRIVE_OFFSET, off);
    write_reg(lss_pkg::REG_DRIVE_LIMIT, lim);
  endtask

  task automatic add_random(input int count);
    for (int i = 0; i < count; i++) sensor_queue.push_back(random_sensor());
  endtask

  // hold off until every sent item has its result back
  task automatic drain();
    while (sensor_queue.size() != 0 || src_valid || steer_expect.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: every single, pair and triple edge case, lost, junk
    src_mode = 1;
    snk_mode = 1;
    sensor_queue.push_back(12'h000);
    for (int i = 0; i < lss_pkg::SENSOR_COUNT; i++)
      sensor_queue.push_back(lss_pkg::SENSOR_COUNT'(1 << i));
    sensor_queue.push_back(12'h003);
    sensor_queue.push_back(12'hC00);
    sensor_queue.push_back(12'h007);
    sensor_queue.push_back(12'hE00);
    sensor_queue.push_back(12'h060);
    sensor_queue.push_back(12'hFFF);
    sensor_queue.push_back(12'h005);
    sensor_queue.push_back(12'h00F);
    sensor_queue.push_back(12'h000);
    sensor_queue.push_back(12'h801);
    drain();

    // zero gains, zero threshold and zero limit: drive clamps to nothing
    src_mode = 0;
    snk_mode = 2;
    set_config(0, 0, 0, 0, 0);
    add_random(40);
    drain();

    src_mode = 2;
    snk_mode = 0;
    set_config(255, 255, 15, 255, 1023);
    add_random(40);
    drain();

    // threshold out of reach: straight gain only
    src_mode = 1;
    snk_mode = 1;
    set_config(255, 3, 12, 0, 1023);
    add_random(40);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      src_mode = $urandom_range(0, 2);
      snk_mode = $urandom_range(0, 2);
      set_config($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 15),
                 ($urandom_range(0, 1) != 0) ? $urandom_range(0, 40) : $urandom_range(0, 255),
                 $urandom_range(0, 1023));
      add_random(80);
      drain();
    end

    repeat (16) @(posedge clk);
    if (err_count == 0 && steer_expect.size() == 0)
      $display("line_sensor_steering test passed");
    else
      $display("line_sensor_steering test failed");
    $finish;
  end

endmodule
`default_nettype wire

>>> filelist.f
hw/rtl/lss_pkg.sv
hw/rtl/lss_if.sv
hw/rtl/lss_decode.sv
hw/rtl/lss_mac.sv
hw/rtl/line_sensor_steering.sv
bench/tb_line_sensor_steering.sv
